// ----- rtl/amx_pkg.sv -----
// Shared constants, codes and types of the two-stream audio mixer.
package amx_pkg;

  // Sample and register widths.
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned FRAME_W   = 24;
  localparam int unsigned CH_IDX_W  = 3;
  localparam int unsigned CH_CNT_W  = 4;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned FRAC_W    = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Most channels per frame.
  localparam logic [CH_CNT_W-1:0] MAX_CHANNELS = 4'd8;

  // Q1.16 unity and the quotient width of the blend divider.
  localparam int unsigned Q_W = 16;
  localparam logic [FRAC_W-1:0] Q16_ONE = 17'h10000;

  // Divider numerator and step counter widths.
  localparam int unsigned NUM_W   = FRAME_W + Q_W;
  localparam int unsigned DIV_CNT_W = $clog2(Q_W);

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_A_W = FRAME_W + 1;
  localparam int unsigned MUL_B_W = FRAC_W + 1;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned MIX_W   = 2 * SAMPLE_W + 3;

  // Mix modes.
  localparam logic [MODE_W-1:0] MODE_AVG  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_XF   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADD  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SUB  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC   = 3'd3;

  // Control from the sequencer to the divider.
  typedef struct packed {
    logic load;
    logic run;
  } div_ctrl_t;

endpackage

// ----- rtl/amx_div.sv -----
// Restoring divider that produces the 16-bit crossfade blend one bit per cycle.
module amx_div
  import amx_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_ctrl_t            ctrl_i,
  input  logic [NUM_W-1:0]     num_i,
  input  logic [FRAME_W-1:0]   den_i,
  output logic [Q_W-1:0]       quot_o,
  output logic                 last_o
);

  logic [FRAME_W-1:0]   rem_q, rem_d;
  logic [Q_W-1:0]       quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [FRAME_W:0]     trial;
  logic [FRAME_W:0]     diff;
  logic                 qbit;

  // One compare-subtract step: bring down the next numerator bit and try the divisor.
  always_comb begin
    trial = {rem_q, quo_q[Q_W-1]};
    diff  = trial - {1'b0, den_i};
    qbit  = ~diff[FRAME_W];
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      rem_d = num_i[NUM_W-1:Q_W];
      quo_d = num_i[Q_W-1:0];
      cnt_d = '0;
    end else if (ctrl_i.run) begin
      rem_d = qbit ? diff[FRAME_W-1:0] : trial[FRAME_W-1:0];
      quo_d = {quo_q[Q_W-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quot_o = quo_q;
  assign last_o = ctrl_i.run && (cnt_q == DIV_CNT_W'(Q_W - 1));

endmodule

// ----- rtl/audio_two_stream_mixer.sv -----
// Top level of the two-stream audio mixer: handshakes, registers, counters and sequencer.
//
// Each input beat carries one sample of each stream for the current channel and frame and
// yields one mixed sample. Average, saturating add and saturating subtract are computed as
// the beat is taken. For a crossfade one shared 25x18 multiplier forms frame*fraction, a
// restoring divider then produces the Q0.16 blend, and the same multiplier forms the weighted
// difference before the final rounding toward zero. The input is not ready while a beat is
// being worked on; a finished sample waits in the output register, so the next beat is taken
// as soon as the sequencer returns to idle. Configuration writes are always ready and must be
// issued only while the block is idle.
module audio_two_stream_mixer
  import amx_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_a_i,
  input  logic signed [SAMPLE_W-1:0] sample_b_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [SAMPLE_W-1:0] mixed_sample_o
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]               state_q, state_d;
  logic [MODE_W-1:0]        mode_q;
  logic [CH_CNT_W-1:0]      chan_cnt_q;
  logic [FRAME_W-1:0]       total_q;
  logic [FRAC_W-1:0]        frac_q;
  logic [FRAME_W-1:0]       frame_q, frame_d;
  logic [CH_IDX_W-1:0]      ch_q, ch_d;
  logic signed [SAMPLE_W-1:0] a_q, b_q;
  logic [FRAME_W-1:0]       f_q;
  logic signed [MIX_W-1:0]  prod_q;
  logic signed [SAMPLE_W-1:0] res_q, res_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_q;

  logic                     in_acc;
  logic                     out_load;
  logic [CH_CNT_W-1:0]      eff_ch;
  logic [CH_CNT_W-1:0]      ch_next;
  logic [FRAME_W-1:0]       eff_total;
  logic [FRAME_W-1:0]       last_frame;
  logic [FRAC_W-1:0]        eff_frac;
  logic signed [SAMPLE_W:0] sum_ab;
  logic signed [SAMPLE_W:0] dif_ab;
  logic signed [SAMPLE_W-1:0] fast_res;
  logic signed [SAMPLE_W:0] dif_ba;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [MIX_W-1:0]  mix;
  logic [Q_W-1:0]           blend;
  logic                     div_last;
  div_ctrl_t                div_ctrl;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_AVG;
      chan_cnt_q <= CH_CNT_W'(2);
      total_q    <= FRAME_W'(1);
      frac_q     <= Q16_ONE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE:  mode_q     <= cfg_data_i[MODE_W-1:0];
        REG_CHAN:  chan_cnt_q <= cfg_data_i[CH_CNT_W-1:0];
        REG_TOTAL: total_q    <= cfg_data_i[FRAME_W-1:0];
        REG_FRAC:  frac_q     <= cfg_data_i[FRAC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective register values with out-of-range settings clamped.
  always_comb begin
    if (chan_cnt_q == '0) begin
      eff_ch = CH_CNT_W'(1);
    end else if (chan_cnt_q > MAX_CHANNELS) begin
      eff_ch = MAX_CHANNELS;
    end else begin
      eff_ch = chan_cnt_q;
    end
    eff_total  = (total_q == '0) ? FRAME_W'(1) : total_q;
    last_frame = eff_total - 1'b1;
    eff_frac   = (frac_q > Q16_ONE) ? Q16_ONE : frac_q;
  end

  // Channel and frame position, advanced once per accepted beat.
  always_comb begin
    ch_next = {1'b0, ch_q} + 1'b1;
    ch_d    = ch_q;
    frame_d = frame_q;
    if (in_acc) begin
      if (ch_next >= eff_ch) begin
        ch_d    = '0;
        frame_d = (frame_q >= last_frame) ? last_frame : frame_q + 1'b1;
      end else begin
        ch_d = ch_next[CH_IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q    <= '0;
      frame_q <= '0;
    end else begin
      ch_q    <= ch_d;
      frame_q <= frame_d;
    end
  end

  // Combinational modes: halve toward zero, or saturate the sum or difference.
  always_comb begin
    sum_ab = {sample_a_i[SAMPLE_W-1], sample_a_i} + {sample_b_i[SAMPLE_W-1], sample_b_i};
    dif_ab = {sample_a_i[SAMPLE_W-1], sample_a_i} - {sample_b_i[SAMPLE_W-1], sample_b_i};
    case (mode_q)
      MODE_AVG: begin
        fast_res = sum_ab[SAMPLE_W:1] + SAMPLE_W'(sum_ab[SAMPLE_W] & sum_ab[0]);
      end
      MODE_ADD: begin
        if (sum_ab[SAMPLE_W] != sum_ab[SAMPLE_W-1]) begin
          fast_res = sum_ab[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                      : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
          fast_res = sum_ab[SAMPLE_W-1:0];
        end
      end
      default: begin
        if (dif_ab[SAMPLE_W] != dif_ab[SAMPLE_W-1]) begin
          fast_res = dif_ab[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                      : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
          fast_res = dif_ab[SAMPLE_W-1:0];
        end
      end
    endcase
  end

  // Shared multiplier: frame times fraction first, then (b - a) times blend.
  always_comb begin
    dif_ba = {b_q[SAMPLE_W-1], b_q} - {a_q[SAMPLE_W-1], a_q};
    if (state_q == ST_MUL1) begin
      mul_a = {1'b0, f_q};
      mul_b = {1'b0, eff_frac};
    end else begin
      mul_a = {{(MUL_A_W-SAMPLE_W-1){dif_ba[SAMPLE_W]}}, dif_ba};
      mul_b = {{(MUL_B_W-Q_W){1'b0}}, blend};
    end
    mul_p = mul_a * mul_b;
  end

  assign div_ctrl.load = (state_q == ST_MUL1);
  assign div_ctrl.run  = (state_q == ST_DIV);

  amx_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (mul_p[NUM_W-1:0]),
    .den_i  (eff_total),
    .quot_o (blend),
    .last_o (div_last)
  );

  // Final crossfade sum a*65536 + (b - a)*blend, divided by 65536 toward zero.
  always_comb begin
    mix = {{(MIX_W-2*SAMPLE_W){a_q[SAMPLE_W-1]}}, a_q, {SAMPLE_W{1'b0}}} + prod_q;
  end

  // Sequencer.
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_d   = fast_res;
          state_d = (mode_q == MODE_XF) ? ST_MUL1 : ST_DONE;
        end
      end
      ST_MUL1: state_d = ST_DIV;
      ST_DIV: begin
        if (div_last) begin
          state_d = ST_MUL2;
        end
      end
      ST_MUL2: state_d = ST_FIN;
      ST_FIN: begin
        res_d   = mix[2*SAMPLE_W-1:SAMPLE_W]
                + SAMPLE_W'(mix[MIX_W-1] && (mix[SAMPLE_W-1:0] != '0));
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Item operands, clamped frame, product and pending result.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_acc) begin
      a_q <= sample_a_i;
      b_q <= sample_b_i;
      f_q <= (frame_q > last_frame) ? last_frame : frame_q;
    end
    if (state_q == ST_MUL2) begin
      prod_q <= mul_p[MIX_W-1:0];
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = out_q;

endmodule

// ----- rtl/amx_checker.sv -----
// Port-level checker of the two-stream audio mixer and its bind to the top level.
module amx_checker
  import amx_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SAMPLE_W-1:0]    mixed_sample_o
);

  logic       in_beat;
  logic       out_beat;
  logic [1:0] open_q;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  // Beats accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + 2'(in_beat) - 2'(out_beat);
    end
  end

  // A result is shown only for a beat that was taken.
  a_out_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (open_q != 2'd0))
    else $error("output valid with no beat outstanding");

  // At most one beat in work and one waiting at the output.
  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q != 2'd3)
    else $error("too many beats outstanding");

  // The block takes one beat at a time.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !in_ready_o)
    else $error("input ready right after a beat was taken");

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(mixed_sample_o)))
    else $error("stalled output changed");

endmodule

bind audio_two_stream_mixer amx_checker u_amx_checker (.*);

// ----- tb/tb_audio_two_stream_mixer.sv -----
// Self-checking testbench for the two-stream audio mixer: directed beats, then random phases.
module tb_audio_two_stream_mixer;
  import amx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_BEATS = 1950;
  localparam longint unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned DRAIN_CYCLES = 40;

  // Register indexes past the last defined one are decoded as no-ops.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [CFG_IDX_W-1:0]          cfg_index_i;
  logic [CFG_DATA_W-1:0]         cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic signed [SAMPLE_W-1:0]    sample_a_i;
  logic signed [SAMPLE_W-1:0]    sample_b_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic signed [SAMPLE_W-1:0]    mixed_sample_o;

  // One line of the directed plan: either a register write or a sample beat.
  typedef struct {
    bit                         is_cfg;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_DATA_W-1:0]      data;
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    bit                         has_lit;
    logic signed [SAMPLE_W-1:0] lit;
  } plan_row_t;

  // Shadow of the block's registers and position counters.
  logic [MODE_W-1:0]   cur_mode;
  logic [CH_CNT_W-1:0] cur_chans;
  logic [FRAME_W-1:0]  cur_total;
  logic [FRAC_W-1:0]   cur_fade;
  logic [FRAME_W-1:0]  frame_pos;
  int                  chan_pos;

  logic signed [SAMPLE_W-1:0] mixed_due[$];
  logic signed [SAMPLE_W-1:0] mixed_want;
  int unsigned                mismatch_count = 0;
  longint unsigned            cycle_count = 0;
  int unsigned                beats_sent;
  bit                         no_gaps;
  plan_row_t                  plan[$];

  audio_two_stream_mixer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_a_i     (sample_a_i),
    .sample_b_i     (sample_b_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mixed_sample_o (mixed_sample_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint clamp16(input longint v);
    if (v > longint'(S_MAX)) return longint'(S_MAX);
    if (v < longint'(S_MIN)) return longint'(S_MIN);
    return v;
  endfunction

  // Mirror a register write into the shadow; unknown indexes change nothing.
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MODE:  cur_mode = data[MODE_W-1:0];
      REG_CHAN:  cur_chans = data[CH_CNT_W-1:0];
      REG_TOTAL: cur_total = data[FRAME_W-1:0];
      REG_FRAC:  cur_fade = data[FRAC_W-1:0];
      default: ;
    endcase
  endfunction

  // Mixed sample for one beat at the current position, then step the channel and frame.
  function automatic logic signed [SAMPLE_W-1:0] predict_mix(
      input logic signed [SAMPLE_W-1:0] a, input logic signed [SAMPLE_W-1:0] b);
    longint sa, sb, r, span, last, fade, pos, blend, chans, one;
    sa = a;
    sb = b;
    one = longint'(Q16_ONE);
    span = (cur_total == '0) ? 1 : longint'(cur_total);
    last = span - 1;
    case (cur_mode)
      MODE_AVG: r = (sa + sb) / 2;
      MODE_XF: begin
        // A frame past the ramp end, left over from a shorter ramp, blends as the last one.
        fade = (cur_fade > Q16_ONE) ? one : longint'(cur_fade);
        pos = (longint'(frame_pos) > last) ? last : longint'(frame_pos);
        blend = pos * fade / span;
        if (blend > one) blend = one;
        r = clamp16((sa * (one - blend) + sb * blend) / one);
      end
      MODE_ADD: r = clamp16(sa + sb);
      default:  r = clamp16(sa - sb);
    endcase
    // A channel count of zero means one channel; counts above the maximum are capped.
    if (cur_chans == '0) chans = 1;
    else if (cur_chans > MAX_CHANNELS) chans = longint'(MAX_CHANNELS);
    else chans = longint'(cur_chans);
    chan_pos++;
    if (chan_pos >= chans) begin
      chan_pos = 0;
      if (longint'(frame_pos) >= last) frame_pos = last[FRAME_W-1:0];
      else frame_pos = frame_pos + 1'b1;
    end
    return r[SAMPLE_W-1:0];
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic plan_row_t beat_row(input logic signed [SAMPLE_W-1:0] a,
                                         input logic signed [SAMPLE_W-1:0] b,
                                         input bit has_lit,
                                         input logic signed [SAMPLE_W-1:0] lit);
    plan_row_t row;
    row = '{default: '0};
    row.a = a;
    row.b = b;
    row.has_lit = has_lit;
    row.lit = lit;
    return row;
  endfunction

  // Idle cycles before a beat: mostly none or a few, now and then a long one.
  function automatic int unsigned input_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return S_MAX;
    if (r == 1) return S_MIN;
    if (r == 2) return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
    return SAMPLE_W'($urandom());
  endfunction

  // Write one register once the block has delivered every pending sample.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (mixed_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one sample pair; valid is left high so back-to-back beats need no extra step.
  task automatic send_beat(input logic signed [SAMPLE_W-1:0] a,
                           input logic signed [SAMPLE_W-1:0] b,
                           input bit has_lit,
                           input logic signed [SAMPLE_W-1:0] lit);
    int unsigned gap;
    logic signed [SAMPLE_W-1:0] want;
    want = predict_mix(a, b);
    if (has_lit) want = lit;
    gap = no_gaps ? 0 : input_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_a_i <= a;
    sample_b_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    mixed_due.push_back(want);
    beats_sent++;
  endtask

  // Receiver readiness: runs of ready broken by stalls, with occasional long clean stretches.
  initial begin
    int unsigned run, stall, r;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 70) run = $urandom_range(1, 6);
      else if (r < 95) run = $urandom_range(7, 30);
      else run = $urandom_range(100, 300);
      r = $urandom_range(0, 99);
      if (r < 60) stall = $urandom_range(1, 2);
      else if (r < 90) stall = $urandom_range(3, 8);
      else stall = $urandom_range(20, 60);
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat (run - 1) @(negedge clk_i);
      @(negedge clk_i);
      out_ready_i <= 1'b0;
      repeat (stall - 1) @(negedge clk_i);
    end
  end

  // Compare every output beat with the oldest pending sample.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (mixed_due.size() == 0) begin
        $display("%0t: unexpected mixed_sample %0d with nothing pending", $time,
                 mixed_sample_o);
        mismatch_count++;
      end else begin
        mixed_want = mixed_due.pop_front();
        if (mixed_sample_o !== mixed_want) begin
          $display("%0t: mixed_sample expected %0d got %0d", $time, mixed_want,
                   mixed_sample_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] data;
    int unsigned r, n;

    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sample_a_i = '0;
    sample_b_i = '0;
    beats_sent = 0;
    no_gaps = 1'b0;
    cur_mode = MODE_AVG;
    cur_chans = 4'd2;
    cur_total = 24'd1;
    cur_fade = Q16_ONE;
    frame_pos = '0;
    chan_pos = 0;

    plan = '{
      // Reset state averages; halving truncates toward zero.
      beat_row(S_MAX, S_MAX, 1, S_MAX),
      beat_row(S_MIN, S_MIN, 1, S_MIN),
      beat_row(S_MAX, S_MIN, 1, 16'sd0),
      beat_row(-16'sd1, 16'sd0, 1, 16'sd0),
      beat_row(16'sd3, 16'sd0, 1, 16'sd1),
      // Saturating add.
      cfg_row(REG_MODE, CFG_DATA_W'(MODE_ADD)),
      beat_row(S_MAX, 16'sd1, 1, S_MAX),
      beat_row(S_MIN, -16'sd1, 1, S_MIN),
      beat_row(16'sh5555, 16'sh2AAA, 1, S_MAX),
      // Saturating subtract.
      cfg_row(REG_MODE, CFG_DATA_W'(MODE_SUB)),
      beat_row(S_MIN, S_MAX, 1, S_MIN),
      beat_row(S_MAX, S_MIN, 1, S_MAX),
      beat_row(16'sd0, S_MIN, 1, S_MAX),
      // Crossfade over a four-frame ramp, one channel, then hold at the last frame.
      cfg_row(REG_MODE, CFG_DATA_W'(MODE_XF)),
      cfg_row(REG_TOTAL, 24'd4),
      cfg_row(REG_CHAN, 24'd1),
      beat_row(16'sd1000, -16'sd1000, 1, 16'sd1000),
      beat_row(16'sd1000, -16'sd1000, 0, '0),
      beat_row(16'sd1000, -16'sd1000, 0, '0),
      beat_row(16'sd1000, -16'sd1000, 0, '0),
      beat_row(16'sd1000, -16'sd1000, 0, '0),
      // Shorter ramp leaves the frame counter past its end.
      cfg_row(REG_TOTAL, 24'd2),
      beat_row(S_MIN, S_MAX, 0, '0),
      // Oversized fraction and a zero channel count.
      cfg_row(REG_FRAC, 24'h01FFFF),
      cfg_row(REG_CHAN, 24'd0),
      beat_row(S_MAX, S_MIN, 0, '0),
      // Oversized channel count and a write to an unused index.
      cfg_row(REG_CHAN, 24'd15),
      cfg_row(REG_SPARE_FIRST + 3'd1, 24'hFFFFFF),
      beat_row(S_MIN, -16'sd1, 0, '0),
      // Zero ramp length with no fade keeps the first stream.
      cfg_row(REG_TOTAL, 24'd0),
      cfg_row(REG_FRAC, 24'd0),
      beat_row(16'sd12345, -16'sd12345, 0, '0),
      // Longest ramp, eight channels, then shrink the count under the channel position.
      cfg_row(REG_TOTAL, 24'hFFFFFF),
      cfg_row(REG_FRAC, CFG_DATA_W'(Q16_ONE)),
      cfg_row(REG_CHAN, 24'd8),
      beat_row(S_MAX, S_MIN, 0, '0),
      beat_row(S_MIN, S_MAX, 0, '0),
      beat_row(-16'sd2, 16'sd7, 0, '0),
      cfg_row(REG_CHAN, 24'd2),
      beat_row(16'sd100, -16'sd100, 0, '0),
      beat_row(16'sd100, -16'sd100, 0, '0)
    };

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed plan.
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].data);
      else send_beat(plan[i].a, plan[i].b, plan[i].has_lit, plan[i].lit);
    end

    // Random phases: a fresh setting, then a run of beats under it.
    n = beats_sent + RANDOM_BEATS;
    while (beats_sent < n) begin
      if ($urandom_range(0, 4) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  CFG_DATA_W'($urandom()));
      end
      if ($urandom_range(0, 3) != 0) begin
        data = CFG_DATA_W'($urandom());
        data[MODE_W-1:0] = ($urandom_range(0, 9) < 4) ? MODE_XF
                                                      : MODE_W'($urandom_range(0, 3));
        write_reg(REG_MODE, data);
      end
      if ($urandom_range(0, 3) != 0) begin
        data = CFG_DATA_W'($urandom());
        r = $urandom_range(0, 9);
        if (r < 8) data[CH_CNT_W-1:0] = CH_CNT_W'($urandom_range(1, 8));
        else if (r == 8) data[CH_CNT_W-1:0] = '0;
        else data[CH_CNT_W-1:0] = CH_CNT_W'($urandom_range(9, 15));
        write_reg(REG_CHAN, data);
      end
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 19);
        if (r == 0) data = '0;
        else if (r == 1) data = 24'd1;
        else if (r == 2) data = 24'hFFFFFF;
        else if (r < 5) data = CFG_DATA_W'($urandom_range(17, 400));
        else if (r == 5) data = CFG_DATA_W'($urandom());
        else data = CFG_DATA_W'($urandom_range(1, 16));
        write_reg(REG_TOTAL, data);
      end
      if ($urandom_range(0, 3) != 0) begin
        data = CFG_DATA_W'($urandom());
        r = $urandom_range(0, 9);
        if (r == 0) data[FRAC_W-1:0] = '0;
        else if (r == 1) data[FRAC_W-1:0] = Q16_ONE;
        else if (r == 2) data[FRAC_W-1:0] = FRAC_W'($urandom_range(65537, 131071));
        else data[FRAC_W-1:0] = FRAC_W'($urandom_range(0, 65536));
        write_reg(REG_FRAC, data);
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(4, 60)) send_beat(pick_sample(), pick_sample(), 0, '0);
    end

    // Drain the pipeline, then report.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (mixed_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- audio_two_stream_mixer.f -----
rtl/amx_pkg.sv
rtl/amx_div.sv
rtl/audio_two_stream_mixer.sv
rtl/amx_checker.sv
tb/tb_audio_two_stream_mixer.sv
